FILE: src/lpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_pkg
// Types and constants shared by the length-prefixed string deframer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam int unsigned LenW  = 31;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 3;

  localparam logic [CntW-1:0] LastPrefixCnt = 3'd4;
  localparam logic [7:0]      MoreBit       = 8'b1000_0000;
  localparam logic [7:0]      Low7Mask      = 8'b0111_1111;
  localparam logic [7:0]      Low3Mask      = 8'b0000_0111;

  typedef enum logic [1:0] {
    KIND_LENGTH       = 2'd0,
    KIND_PAYLOAD      = 2'd1,
    KIND_FORMAT_ERROR = 2'd2,
    KIND_TRUNCATED    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PHASE_PREFIX  = 2'd0,
    PHASE_PAYLOAD = 2'd1
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [LenW-1:0]   len;
    logic [ByteW-1:0]  pbyte;
    logic              last;
  } result_t;

endpackage

FILE: src/length_prefixed_string_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer
// Path: an accepted byte passes through the input register, then the result register.
// Throughput: one item per cycle; the input stalls only while both registers
// hold an item and the result is stalled.
// Reset: rst_ni clears both valid flags and the decode state at once.
// ----------------------------------------------------------------------------
module length_prefixed_string_deframer import lpsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             end_of_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [LenW-1:0]  string_length_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic             is_last_o
);

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] byte_q;
  logic             eod_q;
  logic             accept;
  logic             advance;
  logic             out_free;
  logic             res_vld;
  result_t          res;

  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept || (in_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eod_q  <= end_of_data_i;
    end
  end

  lpsd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .data_byte_i   (byte_q),
    .end_of_data_i (eod_q),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  lpsd_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .res_vld_i       (res_vld),
    .res_i           (res),
    .free_o          (out_free),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .result_kind_o   (result_kind_o),
    .string_length_o (string_length_o),
    .payload_byte_o  (payload_byte_o),
    .is_last_o       (is_last_o)
  );

endmodule

FILE: src/lpsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_core
// Prefix decode and payload count: one item per step, at most one result.
// ----------------------------------------------------------------------------
module lpsd_core import lpsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             end_of_data_i,
  output logic             res_vld_o,
  output result_t          res_o
);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] rem_q, rem_d;

  logic            in_payload;
  logic [LenW-1:0] rem_dec;
  logic [LenW-1:0] acc_new;
  logic [LenW-1:0] low7_ext;
  logic            fifth_bad;
  logic            prefix_done;

  assign in_payload = (phase_q == PHASE_PAYLOAD);
  assign rem_dec    = rem_q - {{(LenW-1){1'b0}}, 1'b1};
  assign low7_ext   = {{(LenW-7){1'b0}}, data_byte_i[6:0]};
  assign fifth_bad  = |(data_byte_i & ~Low3Mask);

  always_comb begin
    case (cnt_q)
      3'd0:    acc_new = acc_q | low7_ext;
      3'd1:    acc_new = acc_q | (low7_ext << 7);
      3'd2:    acc_new = acc_q | (low7_ext << 14);
      3'd3:    acc_new = acc_q | (low7_ext << 21);
      default: acc_new = acc_q | {data_byte_i[2:0], {(LenW-3){1'b0}}};
    endcase
  end

  assign prefix_done = (cnt_q == LastPrefixCnt) ? !fifth_bad
                                                : !(data_byte_i[7]);

  // next state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    if (step_i) begin
      if (end_of_data_i) begin
        if (in_payload || cnt_q != '0) begin
          phase_d = PHASE_PREFIX;
          acc_d   = '0;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end else begin
        case (phase_q)
          PHASE_PAYLOAD: begin
            rem_d = rem_dec;
            if (rem_dec == '0) phase_d = PHASE_PREFIX;
          end
          default: begin
            if (cnt_q == LastPrefixCnt && fifth_bad) begin
              phase_d = PHASE_PREFIX;
              acc_d   = '0;
              cnt_d   = '0;
              rem_d   = '0;
            end else if (prefix_done) begin
              acc_d   = '0;
              cnt_d   = '0;
              rem_d   = acc_new;
              phase_d = (acc_new != '0) ? PHASE_PAYLOAD : PHASE_PREFIX;
            end else begin
              acc_d = acc_new;
              cnt_d = cnt_q + 3'd1;
            end
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    res_vld_o   = 1'b0;
    res_o.kind  = KIND_LENGTH;
    res_o.len   = '0;
    res_o.pbyte = '0;
    res_o.last  = 1'b0;
    if (step_i) begin
      if (end_of_data_i) begin
        if (in_payload || cnt_q != '0) begin
          res_vld_o  = 1'b1;
          res_o.kind = KIND_TRUNCATED;
          res_o.last = 1'b1;
        end
      end else begin
        case (phase_q)
          PHASE_PAYLOAD: begin
            res_vld_o   = 1'b1;
            res_o.kind  = KIND_PAYLOAD;
            res_o.pbyte = data_byte_i;
            res_o.last  = (rem_dec == '0);
          end
          default: begin
            if (cnt_q == LastPrefixCnt && fifth_bad) begin
              res_vld_o  = 1'b1;
              res_o.kind = KIND_FORMAT_ERROR;
              res_o.last = 1'b1;
            end else if (prefix_done) begin
              res_vld_o  = 1'b1;
              res_o.kind = KIND_LENGTH;
              res_o.len  = acc_new;
              res_o.last = (acc_new == '0);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_PREFIX;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastPrefixCnt)
    else $error("prefix count out of range");

  a_payload_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PHASE_PAYLOAD |-> (rem_q != '0 && cnt_q == '0 && acc_q == '0))
    else $error("payload phase with inconsistent counters");

  a_idle_eod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && end_of_data_i && phase_q != PHASE_PAYLOAD && cnt_q == '0)
      |=> ($stable(acc_q) && $stable(rem_q) && cnt_q == '0))
    else $error("end of data between strings changed state");
`endif

endmodule

FILE: src/lpsd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module lpsd_out_reg import lpsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             res_vld_i,
  input  result_t          res_i,
  output logic             free_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [1:0]       result_kind_o,
  output logic [LenW-1:0]  string_length_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic             is_last_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (advance_i) begin
      vld_d = res_vld_i;
    end else if (vld_q && !out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = vld_q;
  assign result_kind_o   = res_q.kind;
  assign string_length_o = res_q.len;
  assign payload_byte_o  = res_q.pbyte;
  assign is_last_o       = res_q.last;

endmodule
